[rtl/rau_pkg.sv]
// Shared types, widths and operation codes for the rotor arithmetic unit.
// Depends on nothing; every other file refers to it by scoped names.
package rau_pkg;

    // Component format: signed Q2.14
    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    // Datapath widths: first products, first sums, second products, second sums
    localparam int PROD_W  = 2 * COMP_WIDTH;
    localparam int SUM1_W  = PROD_W + 2;
    localparam int PROD2_W = SUM1_W + COMP_WIDTH;
    localparam int SUM2_W  = PROD2_W + 2;

    // Operation codes carried in func
    localparam logic [1:0] FUNC_APPLY     = 2'd0;
    localparam logic [1:0] FUNC_APPLY_INV = 2'd1;
    localparam logic [1:0] FUNC_COMBINE   = 2'd2;
    localparam logic [1:0] FUNC_NONE      = 2'd3;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM1_W-1:0]     sum1_t;
    typedef logic signed [PROD2_W-1:0]    prod2_t;
    typedef logic signed [SUM2_W-1:0]     sum2_t;

    // Rounding offsets and saturation limits at the final stage
    localparam sum2_t HALF_VEC = sum2_t'(1) <<< (2 * FRAC_BITS - 1);
    localparam sum2_t HALF_ROT = sum2_t'(1) <<< (FRAC_BITS - 1);
    localparam sum2_t COMP_MAX = (sum2_t'(1) <<< (COMP_WIDTH - 1)) - sum2_t'(1);
    localparam sum2_t COMP_MIN = -COMP_MAX - sum2_t'(1);

    // Beat between front end (first products and sums) and back end
    typedef struct {
        logic [1:0] func;
        comp_t      rot [4];
        sum1_t      s   [4];
    } mid_t;

    // Beat between back end and the rounding stage
    typedef struct {
        logic [1:0] func;
        sum2_t      acc [4];
    } acc_t;

endpackage

[rtl/rau_if.sv]
// Valid/ready channel interfaces for command and result beats.
// Depends on rau_pkg for the component type.
interface rau_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    rau_pkg::comp_t     rot_w;
    rau_pkg::comp_t     rot_x;
    rau_pkg::comp_t     rot_y;
    rau_pkg::comp_t     rot_z;
    rau_pkg::comp_t     opd_a;
    rau_pkg::comp_t     opd_b;
    rau_pkg::comp_t     opd_c;
    rau_pkg::comp_t     opd_d;

    modport source (output valid, func, rot_w, rot_x, rot_y, rot_z,
                    opd_a, opd_b, opd_c, opd_d, input ready);
    modport sink   (input valid, func, rot_w, rot_x, rot_y, rot_z,
                    opd_a, opd_b, opd_c, opd_d, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    rau_pkg::comp_t     res_a;
    rau_pkg::comp_t     res_b;
    rau_pkg::comp_t     res_c;
    rau_pkg::comp_t     res_d;
    logic               saturated;

    modport source (output valid, res_a, res_b, res_c, res_d, saturated, input ready);
    modport sink   (input valid, res_a, res_b, res_c, res_d, saturated, output ready);
endinterface

[rtl/rotor_arithmetic_unit.sv]
// Rotor arithmetic unit top level: front end, back end and rounding stage.
// Depends on rau_pkg, rau_if, rau_front, rau_back, rau_round.
// Pipeline from command beat to result beat: two multiplier ranks, two adder
// ranks, one round/saturate rank. Throughput: one beat per cycle while res.ready
// is high; each stage advances whenever it is empty or its successor advances.
// Reset (rst_n low, asynchronous): all stage valid bits clear; no other state.
module rotor_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    rau_in_if.sink      cmd,
    rau_out_if.source   res
);

    rau_pkg::mid_t      mid;
    logic               mid_valid;
    logic               mid_ready;
    rau_pkg::acc_t      acc;
    logic               acc_valid;
    logic               acc_ready;

    rau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mid       (mid),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready)
    );

    rau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid       (mid),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .acc       (acc),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready)
    );

    rau_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .res       (res)
    );

endmodule

[rtl/rau_front.sv]
// Front end: stage 1 forms all sixteen rotor x operand products, stage 2 sums them
// into the first sandwich half or the rotor product. Depends on rau_pkg, rau_if.
module rau_front (
    input  logic            clk,
    input  logic            rst_n,
    rau_in_if.sink          cmd,
    output rau_pkg::mid_t   mid,
    output logic            mid_valid,
    input  logic            mid_ready
);

    // Stage 1 registers
    logic                   v1_reg;
    logic [1:0]             func1_reg;
    rau_pkg::comp_t         rot1_reg [4];
    rau_pkg::prod_t         prd_reg  [4][4];

    // Stage 2 registers
    logic                   v2_reg;
    rau_pkg::mid_t          mid_reg;

    rau_pkg::comp_t         rot_in [4];
    rau_pkg::comp_t         opd_in [4];
    rau_pkg::prod_t         prd_next [4][4];
    rau_pkg::mid_t          mid_next;
    rau_pkg::sum1_t         bx, by, bz, bq;
    rau_pkg::sum1_t         p [4][4];
    logic                   conj;
    logic                   adv1, adv2;

    // Stall chain: a stage moves when empty or when the next one moves
    assign adv2      = !v2_reg || mid_ready;
    assign adv1      = !v1_reg || adv2;
    assign cmd.ready = adv1;
    assign mid       = mid_reg;
    assign mid_valid = v2_reg;

    // Stage 1: products
    always_comb
    begin
        rot_in = '{cmd.rot_w, cmd.rot_x, cmd.rot_y, cmd.rot_z};
        opd_in = '{cmd.opd_a, cmd.opd_b, cmd.opd_c, cmd.opd_d};
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prd_next[i][j] = rau_pkg::prod_t'(rot_in[i]) * rau_pkg::prod_t'(opd_in[j]);
            end
        end
    end

    // Stage 2: first sums; conjugation flips the bivector terms
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                p[i][j] = rau_pkg::sum1_t'(prd_reg[i][j]);
            end
        end
        conj = (func1_reg == rau_pkg::FUNC_APPLY);
        bx   = p[1][1] - p[3][2];
        by   = p[2][2] - p[1][0];
        bz   = p[3][0] - p[2][1];
        bq   = p[1][2] + p[2][0] + p[3][1];
        if (conj)
        begin
            bx = -bx;
            by = -by;
            bz = -bz;
            bq = -bq;
        end
        mid_next.func = func1_reg;
        mid_next.rot  = rot1_reg;
        if (func1_reg == rau_pkg::FUNC_COMBINE)
        begin
            mid_next.s[0] = p[0][0] - p[1][1] - p[2][2] - p[3][3];
            mid_next.s[1] = p[0][1] + p[1][0] - p[2][3] + p[3][2];
            mid_next.s[2] = p[0][2] + p[1][3] + p[2][0] - p[3][1];
            mid_next.s[3] = p[0][3] - p[1][2] + p[2][1] + p[3][0];
        end
        else
        begin
            mid_next.s[0] = p[0][0] + bx;
            mid_next.s[1] = p[0][1] + by;
            mid_next.s[2] = p[0][2] + bz;
            mid_next.s[3] = bq;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= cmd.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            func1_reg <= cmd.func;
            rot1_reg  <= rot_in;
            prd_reg   <= prd_next;
        end
        if (adv2)
        begin
            mid_reg <= mid_next;
        end
    end

endmodule

[rtl/rau_back.sv]
// Back end: stage 3 multiplies the first sandwich half by the rotor, stage 4
// sums the second half; rotor products pass through. Depends on rau_pkg.
module rau_back (
    input  logic            clk,
    input  logic            rst_n,
    input  rau_pkg::mid_t   mid,
    input  logic            mid_valid,
    output logic            mid_ready,
    output rau_pkg::acc_t   acc,
    output logic            acc_valid,
    input  logic            acc_ready
);

    // Which first-half sum meets rotor part m in output k
    localparam int SIDX [3][4] = '{'{0, 1, 3, 2}, '{1, 0, 2, 3}, '{2, 3, 1, 0}};

    // Stage 3 registers
    logic                   v3_reg;
    logic [1:0]             func3_reg;
    rau_pkg::sum1_t         s3_reg [4];
    rau_pkg::prod2_t        q_reg  [3][4];

    // Stage 4 registers
    logic                   v4_reg;
    rau_pkg::acc_t          acc_reg;

    rau_pkg::prod2_t        q_next [3][4];
    rau_pkg::acc_t          acc_next;
    rau_pkg::sum2_t         q [3][4];
    rau_pkg::sum2_t         bv [3];
    logic                   conj;
    logic                   adv3, adv4;

    assign adv4      = !v4_reg || acc_ready;
    assign adv3      = !v3_reg || adv4;
    assign mid_ready = adv3;
    assign acc       = acc_reg;
    assign acc_valid = v4_reg;

    // Stage 3: second products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                q_next[k][m] = rau_pkg::prod2_t'(mid.s[SIDX[k][m]])
                             * rau_pkg::prod2_t'(mid.rot[m]);
            end
        end
    end

    // Stage 4: second sums, or widen the rotor product
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                q[k][m] = rau_pkg::sum2_t'(q_reg[k][m]);
            end
        end
        conj  = (func3_reg == rau_pkg::FUNC_APPLY);
        bv[0] =  q[0][1] + q[0][2] - q[0][3];
        bv[1] = -q[1][1] + q[1][2] + q[1][3];
        bv[2] =  q[2][1] - q[2][2] + q[2][3];
        acc_next.func = func3_reg;
        if (func3_reg == rau_pkg::FUNC_COMBINE)
        begin
            for (int i = 0; i < 4; i++)
            begin
                acc_next.acc[i] = rau_pkg::sum2_t'(s3_reg[i]);
            end
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc_next.acc[k] = conj ? (q[k][0] - bv[k]) : (q[k][0] + bv[k]);
            end
            acc_next.acc[3] = '0;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
            begin
                v3_reg <= mid_valid;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            func3_reg <= mid.func;
            s3_reg    <= mid.s;
            q_reg     <= q_next;
        end
        if (adv4)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

[rtl/rau_round.sv]
// Output stage: round to nearest (ties up), saturate to the component range
// and hold the result beat, zeroed for FUNC_NONE. Depends on rau_pkg, rau_if.
module rau_round (
    input  logic            clk,
    input  logic            rst_n,
    input  rau_pkg::acc_t   acc,
    input  logic            acc_valid,
    output logic            acc_ready,
    rau_out_if.source       res
);

    logic                   v5_reg;
    rau_pkg::comp_t         res_reg [4];
    logic                   sat_reg;

    rau_pkg::comp_t         res_next [4];
    logic                   sat_next;
    rau_pkg::sum2_t         rnd [4];
    logic                   adv5;

    assign adv5      = !v5_reg || res.ready;
    assign acc_ready = adv5;
    assign res.valid     = v5_reg;
    assign res.res_a     = res_reg[0];
    assign res.res_b     = res_reg[1];
    assign res.res_c     = res_reg[2];
    assign res.res_d     = res_reg[3];
    assign res.saturated = sat_reg;

    // Round, clip, collect the saturation flag
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (acc.func == rau_pkg::FUNC_COMBINE)
            begin
                rnd[i] = (acc.acc[i] + rau_pkg::HALF_ROT) >>> rau_pkg::FRAC_BITS;
            end
            else
            begin
                rnd[i] = (acc.acc[i] + rau_pkg::HALF_VEC) >>> (2 * rau_pkg::FRAC_BITS);
            end
            if (acc.func == rau_pkg::FUNC_NONE)
            begin
                res_next[i] = '0;
            end
            else if (rnd[i] > rau_pkg::COMP_MAX)
            begin
                res_next[i] = rau_pkg::comp_t'(rau_pkg::COMP_MAX);
                sat_next    = 1'b1;
            end
            else if (rnd[i] < rau_pkg::COMP_MIN)
            begin
                res_next[i] = rau_pkg::comp_t'(rau_pkg::COMP_MIN);
                sat_next    = 1'b1;
            end
            else
            begin
                res_next[i] = rau_pkg::comp_t'(rnd[i]);
            end
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv5)
        begin
            v5_reg <= acc_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

endmodule
